// ===== sv/lmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared types and constants of the LED matrix BCM scanner: payload structs,
// command codes, register indexes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lmb_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int PLANE_COUNT = 8;

    localparam int CFG_W      = 7;
    localparam int COLOR_W    = 8;
    localparam int ROW_ADDR_W = 5;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PAIR_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT / 2) : 1;
    localparam int HALF_W  = $clog2(MAX_HEIGHT / 2 + 1);
    localparam int WORD_W  = $clog2(2 * MAX_WIDTH + 5);
    localparam int PLANE_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int DWELL_W = PLANE_COUNT;

    localparam int BANK_WORDS = (2 ** ROW_W) * (2 ** COL_W);
    localparam int MEM_DEPTH  = 2 * BANK_WORDS;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
    localparam int PIXEL_W    = 3 * COLOR_W;

    localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [1:0] CMD_SWAP      = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;

    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(64);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(32);

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         pixel_column;
        logic [5:0]         pixel_row;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } item_t;

    typedef struct packed {
        logic                  red_top;
        logic                  green_top;
        logic                  blue_top;
        logic                  red_bottom;
        logic                  green_bottom;
        logic                  blue_bottom;
        logic [ROW_ADDR_W-1:0] row_address;
        logic                  latch;
        logic                  output_blank;
        logic                  shift_clock;
    } result_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic item_is_tick;
    } dp_status_t;

    function automatic logic [DWELL_W-1:0] dwell_limit(input logic [PLANE_W-1:0] plane);
        dwell_limit = DWELL_W'(1) << plane;
    endfunction

endpackage

// ===== sv/lmb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== sv/lmb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_ctrl
// Controller: clearing pass after reset, item acceptance, frame read wait and
// result register handshake.
// ----------------------------------------------------------------------------
module lmb_ctrl
    import lmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        cmd.clear_en    = (state_reg == S_CLEAR);
        cmd.accept      = (state_reg == S_IDLE) && item_valid;
        cmd.load_result = (state_reg == S_READ) && (!valid_reg || !result_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.accept && status.item_is_tick)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.load_result)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_result)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

endmodule

// ===== sv/lmb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_dp
// Datapath: panel registers, scan counters, frame memory access, pin word
// assembly and result register.
// ----------------------------------------------------------------------------
module lmb_dp
    import lmb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  item_t            item,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output result_t          result
);

    logic [CFG_W-1:0]      width_reg, width_next;
    logic [CFG_W-1:0]      height_reg, height_next;
    logic                  bank_reg, bank_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [PAIR_W-1:0]     pair_reg, pair_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [DWELL_W-1:0]    dwell_reg, dwell_next;
    logic [MEM_ADDR_W-1:0] clear_addr_reg;

    logic [PLANE_W-1:0]    hold_plane_reg;
    logic                  hold_data_reg;
    logic [ROW_ADDR_W-1:0] hold_row_reg;
    logic                  hold_latch_reg;
    logic                  hold_blank_reg;
    logic                  hold_sclk_reg;
    result_t               result_reg, result_next;

    logic [CFG_W-1:0]      w_eff;
    logic [CFG_W-1:0]      h_eff;
    logic [HALF_W-1:0]     half;
    logic [WORD_W-1:0]     two_w;
    logic [WORD_W-1:0]     row_len;

    logic [PLANE_W-1:0]    p0;
    logic [PAIR_W-1:0]     r0;
    logic [WORD_W-1:0]     wd0;
    logic [DWELL_W-1:0]    d0;
    logic [PAIR_W-1:0]     prev;
    logic [WORD_W-1:0]     wd_inc;
    logic [HALF_W-1:0]     pair_inc;
    logic [PLANE_W:0]      plane_inc;
    logic                  is_data;

    logic                  is_tick;
    logic                  is_set;
    logic                  is_swap;
    logic                  pixel_ok;

    logic                  mem_we;
    logic [MEM_ADDR_W-1:0] mem_waddr;
    logic [PIXEL_W-1:0]    mem_wdata;
    logic [MEM_ADDR_W-1:0] addr_top;
    logic [MEM_ADDR_W-1:0] addr_bot;
    logic [ROW_W-1:0]      row_bot;
    rgb_t                  pix_top;
    rgb_t                  pix_bot;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CFG_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = CFG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (32'(height_reg) < 2)
            h_eff = CFG_W'(2);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        half    = HALF_W'(h_eff >> 1);
        two_w   = WORD_W'({w_eff, 1'b0});
        row_len = two_w + WORD_W'(4);
    end

    always_comb
    begin
        p0  = plane_reg;
        r0  = pair_reg;
        wd0 = word_reg;
        d0  = dwell_reg;
        if (32'(p0) >= PLANE_COUNT)
        begin
            p0 = '0;
            d0 = '0;
        end
        if (HALF_W'(r0) >= half)
        begin
            r0  = '0;
            wd0 = '0;
            d0  = '0;
        end
        if (wd0 >= row_len)
        begin
            wd0 = '0;
            d0  = '0;
        end

        prev      = (r0 == '0) ? PAIR_W'(half - HALF_W'(1)) : r0 - PAIR_W'(1);
        is_data   = (wd0 < two_w);
        wd_inc    = wd0 + WORD_W'(1);
        pair_inc  = HALF_W'(r0) + HALF_W'(1);
        plane_inc = (PLANE_W + 1)'(p0) + (PLANE_W + 1)'(1);
        row_bot   = ROW_W'(r0) + ROW_W'(half);
        addr_top  = {!bank_reg == 1'b0, ROW_W'(r0), COL_W'(wd0 >> 1)};
        addr_bot  = {!bank_reg == 1'b0, row_bot, COL_W'(wd0 >> 1)};
    end

    assign is_tick  = (item.command == CMD_TICK);
    assign is_set   = (item.command == CMD_SET_PIXEL);
    assign is_swap  = (item.command == CMD_SWAP);
    assign pixel_ok = (CFG_W'(item.pixel_column) < w_eff)
                   && (CFG_W'(item.pixel_row) < {half[CFG_W-2:0], 1'b0});

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && cfg_index == REG_PANEL_WIDTH)
            width_next = cfg_data;
        if (cfg_we && cfg_index == REG_PANEL_HEIGHT)
            height_next = cfg_data;
    end

    always_comb
    begin
        bank_next  = bank_reg;
        plane_next = plane_reg;
        pair_next  = pair_reg;
        word_next  = word_reg;
        dwell_next = dwell_reg;
        if (cmd.accept && is_swap)
        begin
            bank_next  = !bank_reg;
            plane_next = '0;
            pair_next  = '0;
            word_next  = '0;
            dwell_next = '0;
        end
        else if (cmd.accept && is_tick)
        begin
            plane_next = p0;
            pair_next  = r0;
            word_next  = wd0;
            dwell_next = d0 + DWELL_W'(1);
            if (d0 >= dwell_limit(p0))
            begin
                dwell_next = '0;
                word_next  = wd_inc;
                if (wd_inc >= row_len)
                begin
                    word_next = '0;
                    pair_next = PAIR_W'(pair_inc);
                    if (pair_inc >= half)
                    begin
                        pair_next  = '0;
                        plane_next = PLANE_W'(plane_inc);
                        if (32'(plane_inc) >= PLANE_COUNT)
                            plane_next = '0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clear_addr_reg;
        mem_wdata = '0;
        if (cmd.clear_en)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.accept && is_set && pixel_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = {!bank_reg, ROW_W'(item.pixel_row), COL_W'(item.pixel_column)};
            mem_wdata = {item.blue, item.green, item.red};
        end
    end

    lmb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MEM_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (cmd.accept && is_tick),
        .raddr_a (addr_top),
        .raddr_b (addr_bot),
        .rdata_a (pix_top),
        .rdata_b (pix_bot)
    );

    always_comb
    begin
        result_next              = result_reg;
        if (cmd.load_result)
        begin
            result_next.red_top      = hold_data_reg & pix_top.red[hold_plane_reg];
            result_next.green_top    = hold_data_reg & pix_top.green[hold_plane_reg];
            result_next.blue_top     = hold_data_reg & pix_top.blue[hold_plane_reg];
            result_next.red_bottom   = hold_data_reg & pix_bot.red[hold_plane_reg];
            result_next.green_bottom = hold_data_reg & pix_bot.green[hold_plane_reg];
            result_next.blue_bottom  = hold_data_reg & pix_bot.blue[hold_plane_reg];
            result_next.row_address  = hold_row_reg;
            result_next.latch        = hold_latch_reg;
            result_next.output_blank = hold_blank_reg;
            result_next.shift_clock  = hold_sclk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            bank_reg       <= 1'b0;
            plane_reg      <= '0;
            pair_reg       <= '0;
            word_reg       <= '0;
            dwell_reg      <= '0;
            clear_addr_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bank_reg   <= bank_next;
            plane_reg  <= plane_next;
            pair_reg   <= pair_next;
            word_reg   <= word_next;
            dwell_reg  <= dwell_next;
            if (cmd.clear_en)
                clear_addr_reg <= clear_addr_reg + MEM_ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_tick)
        begin
            hold_plane_reg <= p0;
            hold_data_reg  <= is_data;
            hold_row_reg   <= ROW_ADDR_W'((wd0 <= two_w) ? prev : r0);
            hold_latch_reg <= (wd0 == two_w + WORD_W'(1));
            hold_blank_reg <= (wd0 == two_w) || (wd0 == two_w + WORD_W'(1));
            hold_sclk_reg  <= is_data & wd0[0];
        end
        result_reg <= result_next;
    end

    assign status.clear_last   = (clear_addr_reg == MEM_ADDR_W'(MEM_DEPTH - 1));
    assign status.item_is_tick = is_tick;
    assign result              = result_reg;

endmodule

// ===== sv/led_matrix_bcm_scanner.sv =====
`timescale 1ns / 1ps
// A timer tick's pin word is read from the frame memory into registers, then
// loaded into the result register once it is free; item_stall stays high until
// then, while set pixel and swap leave the block ready for the next item.
// Reset: a clearing pass writes zero to all 8192 frame memory words, one per
// cycle with item_stall high; register writes are taken as usual.
// ----------------------------------------------------------------------------
// led_matrix_bcm_scanner
// Double-buffered BCM scan-out driver for a two-half RGB LED panel.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scanner
    import lmb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lmb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lmb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix BCM scanner. A directed table and
// phases of random pixel loads, bank swaps, timer ticks and unused commands
// are sent under random idling on both channels. Each panel size after the
// first is applied through the register port between phases. A cycle-free
// model of the scan computes the pin word of every tick, and each word that
// leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    import lmb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTINGS_N = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        item_t   it;
        bit      fixed;
        result_t want;
    } stim_rec_t;

    localparam item_t TICK_ITEM = '{CMD_TICK, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00};
    localparam item_t SWAP_ITEM = '{CMD_SWAP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00};
    localparam result_t NO_WORD = '0;
    localparam result_t W_R15_CLK0 =
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd15, 1'b0, 1'b0, 1'b0};
    localparam result_t W_R15_CLK1 =
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd15, 1'b0, 1'b0, 1'b1};
    localparam result_t W_FIRST_LIT =
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 5'd15, 1'b0, 1'b0, 1'b0};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    led_matrix_bcm_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scan shadow state
    rgb_t             frame_mem [0:1][0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    bit               shown;
    int               sc_plane, sc_pair, sc_word, sc_dwell;
    logic [CFG_W-1:0] cols_reg = WIDTH_RESET;
    logic [CFG_W-1:0] rows_reg = HEIGHT_RESET;

    stim_rec_t stim_q [$];
    result_t   pin_word_q [$];
    stim_rec_t directed_tab [20];

    int  items_queued, items_taken, words_checked, mismatches;
    int  cfg_writes, stalled_offers, top_plane;
    bit  hold_req;

    logic [CFG_W-1:0] set_cols [SETTINGS_N] = '{64, 0, 127, 1, 3, 64, 2, 17, 1};
    logic [CFG_W-1:0] set_rows [SETTINGS_N] = '{32, 0, 127, 64, 5, 2, 1, 63, 2};

    function automatic int eff_cols();
        int w;
        w = cols_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_half();
        int h;
        h = rows_reg;
        if (h < 2)
            h = 2;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h / 2;
    endfunction

    task automatic scan_tick(output result_t r);
        int   w, half, row_len, prev;
        rgb_t top, bot;
        w = eff_cols();
        half = eff_half();
        row_len = 2 * w + 4;
        r = '0;
        if (sc_pair >= half)
        begin
            sc_pair = 0;
            sc_word = 0;
            sc_dwell = 0;
        end
        if (sc_word >= row_len)
        begin
            sc_word = 0;
            sc_dwell = 0;
        end
        if (sc_plane > top_plane)
            top_plane = sc_plane;
        prev = (sc_pair == 0) ? half - 1 : sc_pair - 1;
        if (sc_word < 2 * w)
        begin
            top = frame_mem[shown][sc_pair][sc_word / 2];
            bot = frame_mem[shown][sc_pair + half][sc_word / 2];
            r.red_top      = top.red[sc_plane];
            r.green_top    = top.green[sc_plane];
            r.blue_top     = top.blue[sc_plane];
            r.red_bottom   = bot.red[sc_plane];
            r.green_bottom = bot.green[sc_plane];
            r.blue_bottom  = bot.blue[sc_plane];
            r.row_address  = 5'(prev);
            r.shift_clock  = sc_word[0];
        end
        else if (sc_word == 2 * w)
        begin
            r.row_address  = 5'(prev);
            r.output_blank = 1'b1;
        end
        else if (sc_word == 2 * w + 1)
        begin
            r.row_address  = 5'(sc_pair);
            r.latch        = 1'b1;
            r.output_blank = 1'b1;
        end
        else
            r.row_address = 5'(sc_pair);

        if (sc_dwell >= (1 << sc_plane))
        begin
            sc_dwell = 0;
            sc_word++;
            if (sc_word >= row_len)
            begin
                sc_word = 0;
                sc_pair++;
                if (sc_pair >= half)
                begin
                    sc_pair = 0;
                    sc_plane = (sc_plane + 1) % PLANE_COUNT;
                end
            end
        end
        else
            sc_dwell++;
    endtask

    task automatic model_item(input item_t it, output bit has_word, output result_t r);
        rgb_t px;
        has_word = 1'b0;
        r = '0;
        case (it.command)
            CMD_SET_PIXEL:
            begin
                px.red = it.red;
                px.green = it.green;
                px.blue = it.blue;
                if (it.pixel_column < eff_cols() && it.pixel_row < 2 * eff_half())
                    frame_mem[shown ^ 1'b1][it.pixel_row][it.pixel_column] = px;
            end
            CMD_SWAP:
            begin
                shown = shown ^ 1'b1;
                sc_plane = 0;
                sc_pair = 0;
                sc_word = 0;
                sc_dwell = 0;
            end
            CMD_TICK:
            begin
                scan_tick(r);
                has_word = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_word(input result_t want, input result_t got);
        check_field("red_top", want.red_top, got.red_top);
        check_field("green_top", want.green_top, got.green_top);
        check_field("blue_top", want.blue_top, got.blue_top);
        check_field("red_bottom", want.red_bottom, got.red_bottom);
        check_field("green_bottom", want.green_bottom, got.green_bottom);
        check_field("blue_bottom", want.blue_bottom, got.blue_bottom);
        check_field("row_address", want.row_address, got.row_address);
        check_field("latch", want.latch, got.latch);
        check_field("output_blank", want.output_blank, got.output_blank);
        check_field("shift_clock", want.shift_clock, got.shift_clock);
    endtask

    task automatic queue_phase(input int count, input bit long_run);
        stim_rec_t s;
        int        pick, cols, rows, loads;
        cols = eff_cols();
        rows = 2 * eff_half();
        loads = long_run ? cols * rows : $urandom_range(4, 16);
        for (int i = 0; i < count; i++)
        begin
            s.fixed = 1'b0;
            s.want = NO_WORD;
            s.it.command = CMD_TICK;
            s.it.pixel_column = 6'($urandom);
            s.it.pixel_row = 6'($urandom);
            s.it.red = 8'($urandom);
            s.it.green = 8'($urandom);
            s.it.blue = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (i < loads || (i > loads && pick >= (long_run ? 92 : 70)
                              && pick < (long_run ? 96 : 85)))
            begin
                s.it.command = CMD_SET_PIXEL;
                s.it.pixel_column = 6'($urandom_range(0, cols - 1));
                s.it.pixel_row = 6'($urandom_range(0, rows - 1));
            end
            else if (i == loads)
                s.it.command = CMD_SWAP;
            else if (pick < (long_run ? 92 : 70))
                s.it.command = CMD_TICK;
            else if (pick < (long_run ? 98 : 93))
                s.it.command = CMD_SET_PIXEL;
            else if (long_run || pick < 97)
                s.it.command = CMD_UNUSED;
            else
                s.it.command = CMD_SWAP;
            stim_q.push_back(s);
            items_queued++;
        end
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || pin_word_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_PANEL_WIDTH)
            cols_reg = val;
        else
            rows_reg = val;
        cfg_writes++;
    endtask

    // sender
    initial
    begin
        stim_rec_t s;
        result_t   r;
        bit        has_word;
        bit        burst;
        int        gap;
        item_valid <= 1'b0;
        item <= '0;
        burst = 1'b0;
        forever
        begin
            if (stim_q.size() == 0)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                s = stim_q.pop_front();
                if ($urandom_range(0, 31) == 0)
                    burst = !burst;
                gap = burst ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                item_valid <= 1'b1;
                item <= s.it;
                do
                    @(posedge clk);
                while (item_stall);
                items_taken++;
                model_item(s.it, has_word, r);
                if (has_word)
                    pin_word_q.push_back(s.fixed ? s.want : r);
            end
        end
    end

    // receiver
    initial
    begin
        bit burst;
        int gap;
        burst = 1'b0;
        result_stall <= 1'b1;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
                gap = burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // pin word checker
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (item_valid && item_stall)
                stalled_offers++;
            if (result_valid && !result_stall)
            begin
                if (pin_word_q.size() == 0)
                begin
                    $error("pin word transfer with none expected");
                    mismatches++;
                end
                else
                begin
                    want = pin_word_q.pop_front();
                    compare_word(want, result);
                    words_checked++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        foreach (frame_mem[b, r, c])
            frame_mem[b][r][c] = '0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PANEL_WIDTH;
        cfg_data <= '0;
        directed_tab = '{
            '{TICK_ITEM, 1'b1, W_R15_CLK0},
            '{TICK_ITEM, 1'b1, W_R15_CLK0},
            '{TICK_ITEM, 1'b1, W_R15_CLK1},
            '{'{CMD_SET_PIXEL, 6'd0, 6'd0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
            '{'{CMD_SET_PIXEL, 6'd0, 6'd16, 8'h01, 8'h00, 8'h80}, 1'b0, NO_WORD},
            '{'{CMD_SET_PIXEL, 6'd63, 6'd31, 8'hAA, 8'h55, 8'hFF}, 1'b0, NO_WORD},
            '{'{CMD_SET_PIXEL, 6'd63, 6'd63, 8'h12, 8'h34, 8'h56}, 1'b0, NO_WORD},
            '{'{CMD_SET_PIXEL, 6'd0, 6'd32, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
            '{'{CMD_UNUSED, 6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
            '{SWAP_ITEM, 1'b0, NO_WORD},
            '{TICK_ITEM, 1'b1, W_FIRST_LIT},
            '{TICK_ITEM, 1'b1, W_FIRST_LIT},
            '{TICK_ITEM, 1'b0, NO_WORD},
            '{'{CMD_SET_PIXEL, 6'd31, 6'd0, 8'h80, 8'h40, 8'h20}, 1'b0, NO_WORD},
            '{SWAP_ITEM, 1'b0, NO_WORD},
            '{TICK_ITEM, 1'b1, W_R15_CLK0},
            '{TICK_ITEM, 1'b0, NO_WORD},
            '{TICK_ITEM, 1'b0, NO_WORD},
            '{SWAP_ITEM, 1'b0, NO_WORD},
            '{TICK_ITEM, 1'b0, NO_WORD}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_tab[i])
        begin
            stim_q.push_back(directed_tab[i]);
            items_queued++;
        end

        for (int ph = 0; ph < SETTINGS_N; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                repeat (8) @(posedge clk);
                write_reg(REG_PANEL_WIDTH, set_cols[ph]);
                write_reg(REG_PANEL_HEIGHT, set_rows[ph]);
                cfg_valid <= 1'b0;
            end
            if (ph == 2)
                hold_req = 1'b1;
            queue_phase((ph == SETTINGS_N - 1) ? 1000 : 70, ph == SETTINGS_N - 1);
        end

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d item transfers, %0d pin words checked, %0d register writes.",
                 items_taken, words_checked, cfg_writes);
        $display("Scan reached plane %0d; input held back on %0d offered cycles.",
                 top_plane, stalled_offers);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
